/* sv/lfcf_pkg.sv */
// ----------------------------------------------------------------------------
// lfcf_pkg
// Shared widths, register indexes, control types and the microcode program
// for the lowpass-feedback comb filter.
// ----------------------------------------------------------------------------
package lfcf_pkg;

  // Field and storage widths
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 20;
  localparam int DAMP_W     = 16;
  localparam int LEN_W      = 13;
  localparam int INV_W      = 20;
  localparam int CUT_W      = 18;
  localparam int MAX_DELAY  = 4096;
  localparam int ADDR_W     = $clog2(MAX_DELAY);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Shared multiplier: signed sample-wide operand times unsigned coefficient
  localparam int MUL_A_W = SAMPLE_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int SAT_W   = 32;

  // Fixed-point constants
  localparam int GAIN_FRAC  = 20;
  localparam int DAMP_FRAC  = 16;
  localparam int DAMP_RAW_W = CUT_W + INV_W - DAMP_FRAC;
  localparam logic [DAMP_W:0]   DAMP_ONE  = (DAMP_W + 1)'(1 << DAMP_FRAC);
  localparam logic [DAMP_W-1:0] DAMP_HALF = DAMP_W'(1 << (DAMP_FRAC - 1));

  // Register reset values
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);
  localparam logic [INV_W-1:0] INV_RESET = INV_W'(89478);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_RATE  = CFG_IDX_W'(3);

  // Microcode
  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_HIST_GAIN,
    MUL_CUT_INV,
    MUL_D_ONEM,
    MUL_HIST_DAMP
  } mul_sel_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_IF_NOMODE,
    JMP_END
  } jump_e;

  typedef struct packed {
    mul_sel_e          mul;
    logic              store;
    logic              damp_ld;
    logic              acc_ld;
    logic              fin;
    jump_e             jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic     accept;
    mul_sel_e mul;
    logic     store;
    logic     damp_ld;
    logic     acc_ld;
    logic     fin;
  } ctrl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic mode;
    logic out_blocked;
  } stat_t;

  // Named program steps
  localparam logic [STEP_W-1:0] STEP_FEEDBACK = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_STORE    = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_DAMP     = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_D_ONEM   = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_H_DAMP   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_FINISH   = STEP_W'(5);

  // Program ROM: one control word per step
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{mul: MUL_NONE, store: 1'b0, damp_ld: 1'b0, acc_ld: 1'b0, fin: 1'b0,
          jump: JMP_NEXT, target: '0};
    case (step)
      STEP_FEEDBACK: begin
        w.mul = MUL_HIST_GAIN;
      end
      STEP_STORE: begin
        w.mul    = MUL_CUT_INV;
        w.store  = 1'b1;
        w.jump   = JMP_IF_NOMODE;
        w.target = STEP_D_ONEM;
      end
      STEP_DAMP: begin
        w.damp_ld = 1'b1;
      end
      STEP_D_ONEM: begin
        w.mul = MUL_D_ONEM;
      end
      STEP_H_DAMP: begin
        w.mul    = MUL_HIST_DAMP;
        w.acc_ld = 1'b1;
      end
      STEP_FINISH: begin
        w.fin  = 1'b1;
        w.jump = JMP_END;
      end
      default: begin
        w.jump = JMP_END;
      end
    endcase
    return w;
  endfunction

  // Limit a damp value to one half
  function automatic logic [DAMP_W-1:0] clamp_damp(input logic [DAMP_RAW_W-1:0] v);
    logic [DAMP_W-1:0] r;
    if (v > DAMP_RAW_W'(DAMP_HALF)) begin
      r = DAMP_HALF;
    end else begin
      r = v[DAMP_W-1:0];
    end
    return r;
  endfunction

  // Saturate a wide signed value to the sample width
  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    logic [SAMPLE_W-1:0]     r;
    hi = SAT_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/lowpass_feedback_comb_filter.sv */
// ----------------------------------------------------------------------------
// lowpass_feedback_comb_filter
// Freeverb-style comb filter with a one-pole lowpass in the feedback path.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries mode, sample and cutoff;
//   output channel (out_valid_o / out_stall_i) returns one delayed sample per
//   item. Registers are written through cfg_valid_i / cfg_ready_o with an
//   index and data word; the user must write them only while the block is
//   idle, which the block itself does not enforce; cfg_ready_o is always high.
//   The next item is taken at the edge that delivers the result into the
//   output register, so the block takes no new item before the last is done.
//   This is set by the single shared multiplier: the feedback product,
//   the cutoff product with its damp update in mode 1, and the two lowpass
//   products run one after another under the microcode program.
//   A finished result waits in the output register; while the receiver
//   stalls, a new item is still accepted and computed, and only its last
//   step holds until the output register is free.
//   Reset clears history, damp, the write pointer and the registers to their
//   defaults. The delay memory needs no clearing pass: entries not yet
//   written since reset read as zero, tracked by the write pointer and a
//   wrap flag.
// ----------------------------------------------------------------------------
module lowpass_feedback_comb_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 mode_i,
  input  logic signed [lfcf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [lfcf_pkg::CUT_W-1:0]           cutoff_hz_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lfcf_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lfcf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lfcf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  lfcf_pkg::ctrl_t ctrl;
  lfcf_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  lfcf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  lfcf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .sample_in_i  (sample_in_i),
    .cutoff_hz_i  (cutoff_hz_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o)
  );

  // An accepted item keeps the input side busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not busy after an accepted item");

  // A finished item always shows up on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.fin |=> out_valid_o)
    else $error("finished item not presented");

  // Never overwrite a result the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !ctrl.fin)
    else $error("pending result overwritten");

endmodule

/* sv/lfcf_seq.sv */
// ----------------------------------------------------------------------------
// lfcf_seq
// Microcode sequencer: step counter, program ROM lookup and conditional jump.
// ----------------------------------------------------------------------------
module lfcf_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  lfcf_pkg::stat_t stat_i,
  output logic            in_stall_o,
  output lfcf_pkg::ctrl_t ctrl_o
);

  logic [lfcf_pkg::STEP_W-1:0] step_q, step_d;
  logic                        running_q, running_d;
  lfcf_pkg::ucode_t            word;
  logic                        exec;
  logic                        fin_go;
  logic                        accept;

  // Fetch the control word; hold the last step while the output is full and stalled
  always_comb begin
    word   = lfcf_pkg::ucode_rom(step_q);
    exec   = running_q & ~(word.fin & stat_i.out_blocked);
    fin_go = exec & word.fin;
    accept = in_valid_i & ~in_stall_o;
  end

  // Take a new item in the cycle the previous one finishes
  assign in_stall_o = running_q & ~fin_go;

  // Drive the datapath
  always_comb begin
    ctrl_o.accept  = accept;
    ctrl_o.mul     = exec ? word.mul : lfcf_pkg::MUL_NONE;
    ctrl_o.store   = exec & word.store;
    ctrl_o.damp_ld = exec & word.damp_ld;
    ctrl_o.acc_ld  = exec & word.acc_ld;
    ctrl_o.fin     = fin_go;
  end

  // Advance the step counter
  always_comb begin
    step_d    = step_q;
    running_d = running_q;
    if (exec) begin
      case (word.jump)
        lfcf_pkg::JMP_NEXT: begin
          step_d = step_q + lfcf_pkg::STEP_W'(1);
        end
        lfcf_pkg::JMP_IF_NOMODE: begin
          step_d = stat_i.mode ? step_q + lfcf_pkg::STEP_W'(1) : word.target;
        end
        lfcf_pkg::JMP_END: begin
          running_d = 1'b0;
        end
        default: begin
          running_d = 1'b0;
        end
      endcase
    end
    if (accept) begin
      step_d    = lfcf_pkg::STEP_FEEDBACK;
      running_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= lfcf_pkg::STEP_FEEDBACK;
      running_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      running_q <= running_d;
    end
  end

endmodule

/* sv/lfcf_dp.sv */
// ----------------------------------------------------------------------------
// lfcf_dp
// Datapath: configuration registers, delay memory, shared multiplier,
// accumulator, history and damp registers, output register.
// ----------------------------------------------------------------------------
module lfcf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfcf_pkg::ctrl_t                     ctrl_i,
  output lfcf_pkg::stat_t                     stat_o,
  input  logic                                cfg_we_i,
  input  logic [lfcf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lfcf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                mode_i,
  input  logic signed [lfcf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [lfcf_pkg::CUT_W-1:0]          cutoff_hz_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [lfcf_pkg::SAMPLE_W-1:0] sample_out_o
);

  localparam int SW = lfcf_pkg::SAMPLE_W;
  localparam int PW = lfcf_pkg::PROD_W;
  localparam int AW = lfcf_pkg::ACC_W;

  // Configuration and state registers
  logic [lfcf_pkg::GAIN_W-1:0] gain_q;
  logic [lfcf_pkg::DAMP_W-1:0] damp_q;
  logic [lfcf_pkg::LEN_W-1:0]  len_q;
  logic [lfcf_pkg::INV_W-1:0]  inv_q;
  logic [lfcf_pkg::ADDR_W-1:0] wp_q;
  logic                        wrapped_q;
  logic signed [SW-1:0]        hist_q;
  logic                        out_valid_q;

  // Payload registers
  logic                        mode_q;
  logic signed [SW-1:0]        x_q;
  logic [lfcf_pkg::CUT_W-1:0]  cut_q;
  logic [SW-1:0]               rd_data_q;
  logic                        rd_ok_q;
  logic signed [PW-1:0]        prod_q;
  logic signed [PW-1:0]        acc_q;
  logic signed [SW-1:0]        out_data_q;

  logic [SW-1:0] mem [lfcf_pkg::MAX_DELAY];

  logic [lfcf_pkg::LEN_W-1:0]    len_eff;
  logic [lfcf_pkg::ADDR_W-1:0]   rd_addr;
  logic                          rd_ok_d;
  logic signed [SW-1:0]          d_val;
  logic signed [lfcf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lfcf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]          mul_p;
  logic signed [PW-1:0]          fb_round;
  logic signed [SW+1:0]          fb;
  logic signed [SW+2:0]          sum_w;
  logic [SW-1:0]                 sum_sat;
  logic signed [AW-1:0]          tot;
  logic [SW-1:0]                 hist_new;
  logic [lfcf_pkg::DAMP_W-1:0]   damp_mode;
  logic [lfcf_pkg::DAMP_W:0]     one_minus;

  // Delay length limited to 1..MAX_DELAY; read address trails the write pointer
  always_comb begin
    if (len_q == '0) begin
      len_eff = lfcf_pkg::LEN_W'(1);
    end else if (len_q > lfcf_pkg::LEN_W'(lfcf_pkg::MAX_DELAY)) begin
      len_eff = lfcf_pkg::LEN_W'(lfcf_pkg::MAX_DELAY);
    end else begin
      len_eff = len_q;
    end
    rd_addr = wp_q - len_eff[lfcf_pkg::ADDR_W-1:0];
    // Entries at or past the write pointer are unwritten until the first wrap
    rd_ok_d = wrapped_q |
              ({{(lfcf_pkg::LEN_W-lfcf_pkg::ADDR_W){1'b0}}, wp_q} >= len_eff);
    d_val   = rd_ok_q ? signed'(rd_data_q) : '0;
  end

  // Select multiplier operands
  always_comb begin
    one_minus = lfcf_pkg::DAMP_ONE - {1'b0, damp_q};
    case (ctrl_i.mul)
      lfcf_pkg::MUL_HIST_GAIN: begin
        mul_a = {hist_q[SW-1], hist_q};
        mul_b = {1'b0, gain_q};
      end
      lfcf_pkg::MUL_CUT_INV: begin
        mul_a = {{(lfcf_pkg::MUL_A_W-lfcf_pkg::CUT_W){1'b0}}, cut_q};
        mul_b = {1'b0, inv_q};
      end
      lfcf_pkg::MUL_D_ONEM: begin
        mul_a = {d_val[SW-1], d_val};
        mul_b = {{(lfcf_pkg::MUL_B_W-lfcf_pkg::DAMP_W-1){1'b0}}, one_minus};
      end
      lfcf_pkg::MUL_HIST_DAMP: begin
        mul_a = {hist_q[SW-1], hist_q};
        mul_b = {{(lfcf_pkg::MUL_B_W-lfcf_pkg::DAMP_W){1'b0}}, damp_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Feedback sum, new history and mode damp
  always_comb begin
    fb_round  = prod_q + PW'(64'sd1 <<< (lfcf_pkg::GAIN_FRAC - 1));
    fb        = fb_round[PW-1:lfcf_pkg::GAIN_FRAC];
    sum_w     = {{3{x_q[SW-1]}}, x_q} + {fb[SW+1], fb};
    sum_sat   = lfcf_pkg::sat_sample(lfcf_pkg::SAT_W'(sum_w));
    tot       = {acc_q[PW-1], acc_q} + {prod_q[PW-1], prod_q} +
                AW'(64'sd1 <<< (lfcf_pkg::DAMP_FRAC - 1));
    hist_new  = lfcf_pkg::sat_sample(
                  lfcf_pkg::SAT_W'(signed'(tot[AW-1:lfcf_pkg::DAMP_FRAC])));
    damp_mode = lfcf_pkg::clamp_damp(
                  prod_q[lfcf_pkg::DAMP_FRAC+lfcf_pkg::DAMP_RAW_W-1:lfcf_pkg::DAMP_FRAC]);
  end

  // Delay memory: read on accept, write the saturated sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.store) begin
      mem[wp_q] <= sum_sat;
    end
    if (ctrl_i.accept) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Capture the item and run the arithmetic steps
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      mode_q  <= mode_i;
      x_q     <= sample_in_i;
      cut_q   <= cutoff_hz_i;
      rd_ok_q <= rd_ok_d;
    end
    if (ctrl_i.mul != lfcf_pkg::MUL_NONE) begin
      prod_q <= mul_p;
    end
    if (ctrl_i.acc_ld) begin
      acc_q <= prod_q;
    end
    if (ctrl_i.fin) begin
      out_data_q <= d_val;
    end
  end

  // Configuration, pointer, history, damp and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= '0;
      damp_q      <= '0;
      len_q       <= lfcf_pkg::LEN_RESET;
      inv_q       <= lfcf_pkg::INV_RESET;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      hist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lfcf_pkg::CFG_FEEDBACK_GAIN: gain_q <= cfg_data_i[lfcf_pkg::GAIN_W-1:0];
          lfcf_pkg::CFG_DAMPING: begin
            damp_q <= lfcf_pkg::clamp_damp(
                        lfcf_pkg::DAMP_RAW_W'(cfg_data_i[lfcf_pkg::DAMP_W-1:0]));
          end
          lfcf_pkg::CFG_DELAY_LENGTH: len_q <= cfg_data_i[lfcf_pkg::LEN_W-1:0];
          lfcf_pkg::CFG_INVERSE_RATE: inv_q <= cfg_data_i[lfcf_pkg::INV_W-1:0];
          default: begin
          end
        endcase
      end
      if (ctrl_i.damp_ld && mode_q) begin
        damp_q <= damp_mode;
      end
      if (ctrl_i.store) begin
        wp_q <= wp_q + lfcf_pkg::ADDR_W'(1);
        if (wp_q == '1) begin
          wrapped_q <= 1'b1;
        end
      end
      if (ctrl_i.fin) begin
        hist_q <= signed'(hist_new);
      end
      out_valid_q <= ctrl_i.fin | (out_valid_q & out_stall_i);
    end
  end

  assign stat_o.mode        = mode_q;
  assign stat_o.out_blocked = out_valid_q & out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign sample_out_o       = out_data_q;

endmodule
